// ----- design/lcdt_pkg.sv -----
// Shared package of the LCD line timing controller: field widths, timing constants,
// mode and register index codes, and the configuration and result structs.
// Depends on nothing; every other design file refers to it by scoped names.
package lcdt_pkg;

  localparam int unsigned DOT_W      = 9;
  localparam int unsigned LINE_W     = 8;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ELAPSED_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Line and frame timing, in dots and lines.
  localparam logic [DOT_W-1:0]  DOTS_PER_LINE   = 9'd456;
  localparam logic [LINE_W-1:0] LINES_PER_FRAME = 8'd154;
  localparam logic [LINE_W-1:0] LAST_LINE       = LINES_PER_FRAME - 8'd1;
  localparam logic [LINE_W-1:0] VBLANK_LINE     = 8'd144;
  localparam logic [DOT_W-1:0]  OAM_END         = 9'd80;
  localparam logic [DOT_W-1:0]  TRANSFER_END    = 9'd252;

  // Display modes.
  localparam logic [MODE_W-1:0] MODE_HBLANK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TRANSFER = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_LINE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HBLANK_IRQ_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VBLANK_IRQ_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OAM_IRQ_ENABLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_IRQ_ENABLE  = 3'd5;

  typedef struct packed {
    logic              display_enable;
    logic [LINE_W-1:0] compare_line;
    logic              hblank_irq_enable;
    logic              vblank_irq_enable;
    logic              oam_irq_enable;
    logic              match_irq_enable;
  } cfg_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    logic [MODE_W-1:0] lcd_mode;
    logic              line_match;
    logic              vblank_request;
    logic              stat_request;
    logic              render_start;
  } result_t;

endpackage

// ----- design/lcdt_cfg.sv -----
// Configuration register file of the LCD line timing controller.
// Depends on lcdt_pkg for the register indexes and the cfg_t struct.
module lcdt_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lcdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lcdt_pkg::cfg_t                  cfg
);

  lcdt_pkg::cfg_t cfg_r;
  lcdt_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lcdt_pkg::REG_DISPLAY_ENABLE:    cfg_nxt.display_enable    = cfg_wdata[0];
        lcdt_pkg::REG_COMPARE_LINE:      cfg_nxt.compare_line      = cfg_wdata;
        lcdt_pkg::REG_HBLANK_IRQ_ENABLE: cfg_nxt.hblank_irq_enable = cfg_wdata[0];
        lcdt_pkg::REG_VBLANK_IRQ_ENABLE: cfg_nxt.vblank_irq_enable = cfg_wdata[0];
        lcdt_pkg::REG_OAM_IRQ_ENABLE:    cfg_nxt.oam_irq_enable    = cfg_wdata[0];
        lcdt_pkg::REG_MATCH_IRQ_ENABLE:  cfg_nxt.match_irq_enable  = cfg_wdata[0];
        default:                         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display_enable    <= 1'b1;
      cfg_r.compare_line      <= '0;
      cfg_r.hblank_irq_enable <= 1'b0;
      cfg_r.vblank_irq_enable <= 1'b0;
      cfg_r.oam_irq_enable    <= 1'b0;
      cfg_r.match_irq_enable  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/lcdt_timing.sv -----
// Dot counter, line counter, mode and STAT edge state of the LCD line timing controller,
// with the next-state logic for one beat. Depends on lcdt_pkg.
module lcdt_timing (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lcdt_pkg::cfg_t                 cfg,
  input  logic                           step_en,
  input  logic [lcdt_pkg::ELAPSED_W-1:0] elapsed_dots,
  output lcdt_pkg::result_t              result
);

  logic [lcdt_pkg::DOT_W-1:0]  dot_r,  dot_nxt;
  logic [lcdt_pkg::LINE_W-1:0] line_r, line_nxt;
  logic [lcdt_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic                        match_r, match_nxt;
  logic                        prev_r, prev_nxt;

  logic [lcdt_pkg::DOT_W:0]    sum;
  logic [lcdt_pkg::DOT_W:0]    sum_wrapped;
  logic                        wrap;
  logic [lcdt_pkg::LINE_W-1:0] line_inc;
  logic                        match_wrap;
  logic                        cond_line;
  logic                        cond_vbl;
  logic                        rose_line;
  logic                        rose_vbl;
  logic                        enter_vbl;

  // STAT condition for a given mode and match flag; transfer mode adds nothing.
  function automatic logic stat_cond(input logic [lcdt_pkg::MODE_W-1:0] mode,
                                     input logic match, input lcdt_pkg::cfg_t c);
    logic cond;
    case (mode)
      lcdt_pkg::MODE_HBLANK: cond = c.hblank_irq_enable;
      lcdt_pkg::MODE_VBLANK: cond = c.vblank_irq_enable;
      lcdt_pkg::MODE_OAM:    cond = c.oam_irq_enable;
      default:               cond = 1'b0;
    endcase
    return cond | (c.match_irq_enable & match);
  endfunction

  always_comb begin
    sum         = {1'b0, dot_r} + {{(lcdt_pkg::DOT_W + 1 - lcdt_pkg::ELAPSED_W){1'b0}},
                                   elapsed_dots};
    wrap        = sum >= {1'b0, lcdt_pkg::DOTS_PER_LINE};
    sum_wrapped = sum - {1'b0, lcdt_pkg::DOTS_PER_LINE};
    line_inc    = (line_r == lcdt_pkg::LAST_LINE) ? '0 : line_r + 8'd1;
    match_wrap  = line_inc == cfg.compare_line;
    cond_line   = stat_cond(mode_r, match_wrap, cfg);
    rose_line   = cond_line & ~prev_r;
    enter_vbl   = line_inc == lcdt_pkg::VBLANK_LINE;
    cond_vbl    = stat_cond(lcdt_pkg::MODE_VBLANK, match_wrap, cfg);
    rose_vbl    = cond_vbl & ~cond_line;

    result   = '0;
    dot_nxt  = dot_r;
    line_nxt = line_r;
    mode_nxt = mode_r;
    match_nxt = match_r;
    prev_nxt = prev_r;

    if (!cfg.display_enable) begin
      dot_nxt   = '0;
      line_nxt  = '0;
      mode_nxt  = lcdt_pkg::MODE_HBLANK;
      match_nxt = cfg.compare_line == '0;
      prev_nxt  = 1'b0;
    end else begin
      dot_nxt = wrap ? sum_wrapped[lcdt_pkg::DOT_W-1:0] : sum[lcdt_pkg::DOT_W-1:0];
      if (wrap) begin
        line_nxt  = line_inc;
        match_nxt = match_wrap;
        if (enter_vbl) begin
          prev_nxt              = cond_vbl;
          result.stat_request   = rose_line | rose_vbl;
          result.vblank_request = 1'b1;
        end else begin
          prev_nxt            = cond_line;
          result.stat_request = rose_line;
        end
      end
      if (line_nxt >= lcdt_pkg::VBLANK_LINE) begin
        mode_nxt = lcdt_pkg::MODE_VBLANK;
      end else if (dot_nxt < lcdt_pkg::OAM_END) begin
        mode_nxt = lcdt_pkg::MODE_OAM;
      end else if (dot_nxt < lcdt_pkg::TRANSFER_END) begin
        mode_nxt = lcdt_pkg::MODE_TRANSFER;
        // Across a wrap the counter before the beat counts as negative.
        result.render_start = wrap | (dot_r < lcdt_pkg::OAM_END);
      end else begin
        mode_nxt = lcdt_pkg::MODE_HBLANK;
      end
    end

    result.line_number = line_nxt;
    result.lcd_mode    = mode_nxt;
    result.line_match  = match_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r   <= '0;
      line_r  <= '0;
      mode_r  <= lcdt_pkg::MODE_OAM;
      match_r <= 1'b0;
      prev_r  <= 1'b0;
    end else if (step_en) begin
      dot_r   <= dot_nxt;
      line_r  <= line_nxt;
      mode_r  <= mode_nxt;
      match_r <= match_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

// ----- design/lcd_line_timing_controller_top.sv -----
// Top level of the LCD line timing controller: handshakes, input and result registers.
// Depends on lcdt_pkg, lcdt_cfg and lcdt_timing.

// The controller takes one beat per clock cycle while the output is not stalled, each
// carrying the number of dots that have elapsed, and returns exactly one result beat for
// it: the line number, the display mode, the line-compare flag and the vblank, STAT and
// render pulses. A beat passes an input register and then one short path of logic (a
// 9-bit add, a compare against the line length and the mode thresholds) into the result
// register, so the sustained rate is one beat per cycle while out_ready stays high. A
// beat waits in the input register while the result register is full and stalled. The
// only state carried from beat to beat is the dot counter, line counter, mode, compare
// flag and the last STAT condition, all updated as the beat leaves the input register.
// The input side stays ready while a finished result waits at the output, as long as the
// input register is free or moves on in the same cycle. Configuration registers are
// written through cfg_we, cfg_index and cfg_wdata; they should only be changed while no
// beat is in flight. Indexes beyond the last register are ignored.
module lcd_line_timing_controller_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lcdt_pkg::ELAPSED_W-1:0]  in_elapsed_dots,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lcdt_pkg::LINE_W-1:0]     out_line_number,
  output logic [lcdt_pkg::MODE_W-1:0]     out_lcd_mode,
  output logic                            out_line_match,
  output logic                            out_vblank_request,
  output logic                            out_stat_request,
  output logic                            out_render_start,
  input  logic                            cfg_we,
  input  logic [lcdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  lcdt_pkg::cfg_t    cfg;
  lcdt_pkg::result_t result;
  lcdt_pkg::result_t res_r;

  logic                           in_valid_r;
  logic [lcdt_pkg::ELAPSED_W-1:0] dots_r;
  logic                           out_valid_r;
  logic                           out_free;
  logic                           advance;

  // The result register can take a beat when empty or when its beat leaves now.
  assign out_free = ~out_valid_r | out_ready;
  assign advance  = in_valid_r & out_free;
  assign in_ready = ~in_valid_r | out_free;

  lcdt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lcdt_timing u_timing (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .step_en      (advance),
    .elapsed_dots (dots_r),
    .result       (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dots_r <= in_elapsed_dots;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_line_number    = res_r.line_number;
  assign out_lcd_mode       = res_r.lcd_mode;
  assign out_line_match     = res_r.line_match;
  assign out_vblank_request = res_r.vblank_request;
  assign out_stat_request   = res_r.stat_request;
  assign out_render_start   = res_r.render_start;

endmodule

// ----- design/lcdt_checker.sv -----
// Port-level checker of the LCD line timing controller and its bind to the top level.
// Depends on lcdt_pkg and lcd_line_timing_controller_top.
module lcdt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lcdt_pkg::LINE_W-1:0] out_line_number,
  input logic [lcdt_pkg::MODE_W-1:0] out_lcd_mode,
  input logic                        out_vblank_request,
  input logic                        out_render_start
);

  // A stalled result beat stays valid, with its line number and mode unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_number)
                                && $stable(out_lcd_mode))
    else $error("result beat changed while stalled");

  // A vblank request comes only with the first vblank line and vblank mode.
  a_vblank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_vblank_request |->
      out_line_number == lcdt_pkg::VBLANK_LINE && out_lcd_mode == lcdt_pkg::MODE_VBLANK)
    else $error("vblank request outside vblank entry");

  // A render pulse only comes with transfer mode.
  a_render: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_render_start |-> out_lcd_mode == lcdt_pkg::MODE_TRANSFER)
    else $error("render pulse outside transfer mode");

  // Vblank mode and vblank lines go together, and the line stays within the frame.
  a_mode_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_number <= lcdt_pkg::LAST_LINE
      && ((out_lcd_mode == lcdt_pkg::MODE_VBLANK) ==
          (out_line_number >= lcdt_pkg::VBLANK_LINE)))
    else $error("mode and line number disagree");

endmodule

bind lcd_line_timing_controller_top lcdt_checker u_lcdt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_line_number    (out_line_number),
  .out_lcd_mode       (out_lcd_mode),
  .out_vblank_request (out_vblank_request),
  .out_render_start   (out_render_start)
);
